/* hdl/tmrls_pkg.sv */
// ----------------------------------------------------------------------------
// Thrust map RLS estimator package
// Shared types, codes and fixed-point constants for the thrust map estimator.
// ----------------------------------------------------------------------------
package tmrls_pkg;

  // Request codes carried on req_type.
  localparam logic [1:0] REQ_CMD   = 2'd0;
  localparam logic [1:0] REQ_MEAS  = 2'd1;
  localparam logic [1:0] REQ_RESET = 2'd2;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOVER      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FORGET     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_MIN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_MAX    = 3'd4;
  localparam int unsigned CFG_DATA_W = 24;

  // Register reset values.
  localparam logic [22:0] GRAVITY_RESET = 23'd642908;
  localparam logic [15:0] HOVER_RESET   = 16'd19661;
  localparam logic [23:0] FORGET_RESET  = 24'd16743662;
  localparam logic [19:0] WIN_MIN_RESET = 20'd35000;
  localparam logic [19:0] WIN_MAX_RESET = 20'd45000;

  // Seeded gain for the reset register values, and covariance seed 1e6 in Q24.24.
  localparam logic [63:0] GAIN_RESET_WIDE = (64'd642908 << 16) / 64'd19661;
  localparam logic [23:0] GAIN_RESET = GAIN_RESET_WIDE[23:0];
  localparam logic [63:0] COV_INIT_WIDE = 64'd1000000 << 24;
  localparam logic [47:0] COV_INIT = COV_INIT_WIDE[47:0];
  localparam logic [47:0] COV_MAX = 48'hFFFF_FFFF_FFFF;

  localparam logic signed [23:0] GAIN_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] GAIN_MIN = -24'sh800000;
  localparam logic signed [17:0] THR_MAX  = 18'sh1FFFF;
  localparam logic signed [17:0] THR_MIN  = -18'sh20000;
  localparam logic [40:0] DELTA_CAP = 41'h100_0000_0000;

  // Shared multiply/divide unit operations.
  typedef enum logic {
    MDU_MUL,
    MDU_DIV
  } mdu_op_t;

  typedef struct packed {
    logic    start;
    mdu_op_t op;
    logic [5:0] nbits;
  } mdu_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic ovf;
  } mdu_sts_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_CMD,
    S_CMD_DIV,
    S_CMD_WR,
    S_MRD,
    S_MCHK,
    S_MUL_PT,
    S_MUL_TTP,
    S_MUL_TG,
    S_MUL_PE,
    S_DIV_GAIN,
    S_DIV_COV,
    S_SEED,
    S_DONE
  } state_t;

endpackage

/* hdl/thrust_map_rls_estimator.sv */
// ----------------------------------------------------------------------------
// Thrust map RLS estimator
// Scalar recursive least squares estimate of the thrust-to-acceleration gain,
// with a timestamped throttle history for pairing delayed measurements.
// ----------------------------------------------------------------------------
// Usage:
//   An item is taken when start is high and busy is low. req_type selects a
//   command (accel to throttle), a measurement (RLS update against history)
//   or a reset of the mapping. Every item gives exactly one result, shown for
//   one cycle with result_valid high; the receiver cannot stall it, and
//   gain_now carries the gain after the item during that cycle.
//   Configuration writes use cfg_valid/cfg_ready (always ready), cfg_index
//   and cfg_data; the user makes them while the block is idle (not enforced).
// All work runs through one shared bit-serial multiply/divide unit:
//   command      a divide, then the history write; the divide is skipped
//                when the gain is zero
//   reset item   a divide that seeds the gain from gravity and hover
//   measurement  a read and check per history entry inspected, then,
//                when an update runs, four multiplies, a gain divide and
//                a covariance divide.
// busy stays high through the result cycle; the next item can be taken in
// the cycle after it.
// After reset: registers at their defaults, gain seeded, history empty.
// The history memory needs no clearing pass; the fill count guards it.
// ----------------------------------------------------------------------------
module thrust_map_rls_estimator #(
  parameter int HISTORY_DEPTH = 100
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [1:0]                            req_type,
  input  logic [31:0]                           time_us,
  input  logic signed [23:0]                    accel_z,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [tmrls_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tmrls_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic                                  result_valid,
  output logic signed [17:0]                    throttle,
  output logic                                  updated,
  output logic signed [23:0]                    gain_now
);

  localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int CW = $clog2(HISTORY_DEPTH + 1);
  localparam logic [CW:0] DEPTH_W = (CW + 1)'(HISTORY_DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(HISTORY_DEPTH - 1);

  tmrls_pkg::state_t state;
  tmrls_pkg::state_t state_next;

  // Configuration registers.
  logic [22:0] gravity;
  logic [15:0] hover_fraction;
  logic [23:0] forgetting_factor;
  logic [19:0] window_min_us;
  logic [19:0] window_max_us;

  // Estimator state.
  logic signed [23:0] gain;
  logic [47:0]        cov;
  logic [AW-1:0]      head;
  logic [CW-1:0]      count;

  // History memory with registered read.
  logic [49:0]   mem [HISTORY_DEPTH];
  logic [49:0]   rd_data;
  logic          mem_we;
  logic [AW-1:0] wr_addr;

  // Item and working registers.
  logic [1:0]         type_q;
  logic [31:0]        time_q;
  logic signed [23:0] a_q;
  logic signed [17:0] thr_q;
  logic               upd_q;
  logic [17:0]        at;
  logic               tneg;
  logic [65:0]        r1;
  logic [51:0]        den;
  logic [24:0]        ae;
  logic               eneg;
  logic               launched;

  // Shared unit connections.
  tmrls_pkg::mdu_req_t u_req;
  tmrls_pkg::mdu_sts_t u_sts;
  logic [65:0] u_opnd;
  logic [65:0] u_acc;
  logic [47:0] u_shf;
  logic [83:0] u_prod;
  logic [47:0] u_quo;

  // Derived values.
  logic        accept;
  logic [23:0] a_abs;
  logic [23:0] g_abs;
  logic [31:0] age;
  logic [31:0] entry_time;
  logic signed [17:0] entry_thr;
  logic        is_op_state;
  logic [CW:0] slot_sum;
  logic [AW-1:0] slot;
  logic [AW-1:0] head_inc;

  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign a_abs = a_q[23] ? 24'(-a_q) : 24'(a_q);
  assign g_abs = gain[23] ? 24'(-gain) : 24'(gain);
  assign entry_time = rd_data[49:18];
  assign entry_thr  = rd_data[17:0];
  assign age = time_q - entry_time;
  assign head_inc = (head == LAST_IDX) ? '0 : head + AW'(1);
  assign slot_sum = (CW + 1)'(head) + (CW + 1)'(count);
  assign slot = (slot_sum >= DEPTH_W) ? AW'(slot_sum - DEPTH_W) : AW'(slot_sum);

  tmrls_mdu u_mdu (
    .clk      (clk),
    .rst      (rst),
    .req      (u_req),
    .opnd_in  (u_opnd),
    .acc_init (u_acc),
    .shf_init (u_shf),
    .sts      (u_sts),
    .prod     (u_prod),
    .quo      (u_quo)
  );

  // Configuration write channel.
  always_ff @(posedge clk) begin
    if (rst) begin
      gravity           <= tmrls_pkg::GRAVITY_RESET;
      hover_fraction    <= tmrls_pkg::HOVER_RESET;
      forgetting_factor <= tmrls_pkg::FORGET_RESET;
      window_min_us     <= tmrls_pkg::WIN_MIN_RESET;
      window_max_us     <= tmrls_pkg::WIN_MAX_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tmrls_pkg::CFG_GRAVITY: gravity           <= cfg_data[22:0];
        tmrls_pkg::CFG_HOVER:   hover_fraction    <= cfg_data[15:0];
        tmrls_pkg::CFG_FORGET:  forgetting_factor <= cfg_data;
        tmrls_pkg::CFG_WIN_MIN: window_min_us     <= cfg_data[19:0];
        tmrls_pkg::CFG_WIN_MAX: window_max_us     <= cfg_data[19:0];
        default: ;
      endcase
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      tmrls_pkg::S_IDLE: begin
        if (accept) begin
          unique case (req_type)
            tmrls_pkg::REQ_CMD:   state_next = tmrls_pkg::S_CMD;
            tmrls_pkg::REQ_MEAS:  state_next = tmrls_pkg::S_MRD;
            tmrls_pkg::REQ_RESET: state_next = tmrls_pkg::S_SEED;
            default:              state_next = tmrls_pkg::S_DONE;
          endcase
        end
      end
      tmrls_pkg::S_CMD: begin
        state_next = (gain == '0) ? tmrls_pkg::S_CMD_WR : tmrls_pkg::S_CMD_DIV;
      end
      tmrls_pkg::S_CMD_DIV:  if (u_sts.done) state_next = tmrls_pkg::S_CMD_WR;
      tmrls_pkg::S_CMD_WR:   state_next = tmrls_pkg::S_DONE;
      tmrls_pkg::S_MRD: begin
        state_next = (count == '0) ? tmrls_pkg::S_DONE : tmrls_pkg::S_MCHK;
      end
      tmrls_pkg::S_MCHK: begin
        if (age > {12'd0, window_max_us}) begin
          state_next = tmrls_pkg::S_MRD;
        end else if (age < {12'd0, window_min_us}) begin
          state_next = tmrls_pkg::S_DONE;
        end else begin
          state_next = tmrls_pkg::S_MUL_PT;
        end
      end
      tmrls_pkg::S_MUL_PT:   if (u_sts.done) state_next = tmrls_pkg::S_MUL_TTP;
      tmrls_pkg::S_MUL_TTP:  if (u_sts.done) state_next = tmrls_pkg::S_MUL_TG;
      tmrls_pkg::S_MUL_TG:   if (u_sts.done) state_next = tmrls_pkg::S_MUL_PE;
      tmrls_pkg::S_MUL_PE:   if (u_sts.done) state_next = tmrls_pkg::S_DIV_GAIN;
      tmrls_pkg::S_DIV_GAIN: if (u_sts.done) state_next = tmrls_pkg::S_DIV_COV;
      tmrls_pkg::S_DIV_COV:  if (u_sts.done) state_next = tmrls_pkg::S_DONE;
      tmrls_pkg::S_SEED:     if (u_sts.done) state_next = tmrls_pkg::S_DONE;
      tmrls_pkg::S_DONE:     state_next = tmrls_pkg::S_IDLE;
      default:               state_next = tmrls_pkg::S_IDLE;
    endcase
  end

  // Output and unit-operand decode.
  always_comb begin
    busy         = (state != tmrls_pkg::S_IDLE);
    result_valid = (state == tmrls_pkg::S_DONE);
    mem_we       = (state == tmrls_pkg::S_CMD_WR);
    is_op_state  = 1'b1;
    u_req.op     = tmrls_pkg::MDU_MUL;
    u_req.nbits  = 6'd18;
    u_opnd       = '0;
    u_acc        = '0;
    u_shf        = {at, 30'd0};
    unique case (state)
      tmrls_pkg::S_CMD_DIV: begin
        u_req.op = tmrls_pkg::MDU_DIV;
        u_opnd   = {42'd0, g_abs};
        u_acc    = {44'd0, a_abs[23:2]};
        u_shf    = {a_abs[1:0], 46'd0};
      end
      tmrls_pkg::S_SEED: begin
        u_req.op    = tmrls_pkg::MDU_DIV;
        u_req.nbits = 6'd23;
        u_opnd      = {50'd0, hover_fraction};
        u_acc       = {50'd0, gravity[22:7]};
        u_shf       = {gravity[6:0], 41'd0};
      end
      tmrls_pkg::S_MUL_PT:  u_opnd = {18'd0, cov};
      tmrls_pkg::S_MUL_TTP: u_opnd = r1;
      tmrls_pkg::S_MUL_TG:  u_opnd = {42'd0, g_abs};
      tmrls_pkg::S_MUL_PE: begin
        u_req.nbits = 6'd25;
        u_opnd      = {16'd0, r1[65:16]};
        u_shf       = {ae, 23'd0};
      end
      tmrls_pkg::S_DIV_GAIN: begin
        u_req.op    = tmrls_pkg::MDU_DIV;
        u_req.nbits = 6'd42;
        u_opnd      = {14'd0, den};
        u_acc       = {33'd0, u_prod[74:42]};
        u_shf       = {u_prod[41:0], 6'd0};
      end
      tmrls_pkg::S_DIV_COV: begin
        u_req.op    = tmrls_pkg::MDU_DIV;
        u_req.nbits = 6'd48;
        u_opnd      = {14'd0, den};
        u_acc       = {42'd0, cov[47:24]};
        u_shf       = {cov[23:0], 24'd0};
      end
      default: is_op_state = 1'b0;
    endcase
    u_req.start = is_op_state && !launched;
  end

  // State register and operation launch flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= tmrls_pkg::S_IDLE;
      launched <= 1'b0;
    end else begin
      state <= state_next;
      if (u_sts.done) begin
        launched <= 1'b0;
      end else if (u_req.start) begin
        launched <= 1'b1;
      end
    end
  end

  // History memory.
  assign wr_addr = (count >= CW'(HISTORY_DEPTH)) ? head : slot;
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= {time_q, thr_q};
    end
    rd_data <= mem[head];
  end

  // Estimator datapath.
  logic [18:0]        mag;
  logic               thr_neg;
  logic signed [17:0] thr_div;
  logic [24:0]        tgs;
  logic signed [26:0] tg_signed;
  logic signed [26:0] e_val;
  logic [40:0]        delta;
  logic signed [42:0] gsum;
  logic [23:0]        rho_eff;

  always_comb begin
    mag = u_sts.ovf ? 19'h40000 : {1'b0, u_quo[17:0]};
    thr_neg = a_q[23] ^ gain[23];
    if (thr_neg) begin
      thr_div = (mag >= 19'd131072) ? tmrls_pkg::THR_MIN : 18'(-mag);
    end else begin
      thr_div = (mag > 19'd131071) ? tmrls_pkg::THR_MAX : 18'(mag);
    end
    tgs = u_prod[40:16];
    tg_signed = (tneg ^ gain[23]) ? -27'(tgs) : 27'(tgs);
    e_val = 27'(a_q) - tg_signed;
    delta = (u_sts.ovf || u_quo[41:0] > 42'(tmrls_pkg::DELTA_CAP))
            ? tmrls_pkg::DELTA_CAP : u_quo[40:0];
    if (tneg != eneg) begin
      gsum = 43'(gain) - 43'(delta);
    end else begin
      gsum = 43'(gain) + 43'(delta);
    end
    rho_eff = (forgetting_factor == '0) ? 24'd1 : forgetting_factor;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gain  <= tmrls_pkg::GAIN_RESET;
      cov   <= tmrls_pkg::COV_INIT;
      head  <= '0;
      count <= '0;
    end else begin
      unique case (state)
        tmrls_pkg::S_IDLE: begin
          if (accept) begin
            type_q <= req_type;
            time_q <= time_us;
            a_q    <= accel_z;
            thr_q  <= '0;
            upd_q  <= 1'b0;
          end
        end
        tmrls_pkg::S_CMD: begin
          if (gain == '0) begin
            if (a_q > 0) begin
              thr_q <= tmrls_pkg::THR_MAX;
            end else if (a_q < 0) begin
              thr_q <= tmrls_pkg::THR_MIN;
            end else begin
              thr_q <= '0;
            end
          end
        end
        tmrls_pkg::S_CMD_DIV: if (u_sts.done) thr_q <= thr_div;
        tmrls_pkg::S_CMD_WR: begin
          // A full ring overwrites its oldest entry.
          if (count >= CW'(HISTORY_DEPTH)) begin
            head <= head_inc;
          end else begin
            count <= count + CW'(1);
          end
        end
        tmrls_pkg::S_MCHK: begin
          if (age > {12'd0, window_max_us} || age >= {12'd0, window_min_us}) begin
            head  <= head_inc;
            count <= count - CW'(1);
          end
          at   <= entry_thr[17] ? 18'(-entry_thr) : 18'(entry_thr);
          tneg <= entry_thr[17];
        end
        tmrls_pkg::S_MUL_PT: if (u_sts.done) r1 <= u_prod[65:0];
        tmrls_pkg::S_MUL_TTP: begin
          if (u_sts.done) den <= 52'(rho_eff) + u_prod[83:32];
        end
        tmrls_pkg::S_MUL_TG: begin
          if (u_sts.done) begin
            ae   <= e_val[26] ? 25'(-e_val) : 25'(e_val);
            eneg <= e_val[26];
          end
        end
        tmrls_pkg::S_DIV_GAIN: begin
          if (u_sts.done) begin
            if (gsum > 43'(tmrls_pkg::GAIN_MAX)) begin
              gain <= tmrls_pkg::GAIN_MAX;
            end else if (gsum < 43'(tmrls_pkg::GAIN_MIN)) begin
              gain <= tmrls_pkg::GAIN_MIN;
            end else begin
              gain <= 24'(gsum);
            end
          end
        end
        tmrls_pkg::S_DIV_COV: begin
          if (u_sts.done) begin
            cov   <= u_sts.ovf ? tmrls_pkg::COV_MAX : u_quo;
            upd_q <= 1'b1;
          end
        end
        tmrls_pkg::S_SEED: begin
          if (u_sts.done) begin
            gain <= u_sts.ovf ? tmrls_pkg::GAIN_MAX : {1'b0, u_quo[22:0]};
            cov  <= tmrls_pkg::COV_INIT;
          end
        end
        default: ;
      endcase
    end
  end

  // Result ports; throttle shows thr_q for a command item and zero otherwise.
  assign throttle = (type_q == tmrls_pkg::REQ_CMD) ? thr_q : '0;
  assign updated  = upd_q;
  assign gain_now = gain;

endmodule

/* hdl/tmrls_mdu.sv */
// ----------------------------------------------------------------------------
// Thrust map RLS shared multiply/divide unit
// One wide adder used one bit per cycle: MSB-first shift-add multiply or
// restoring divide with an up-front quotient overflow check.
// ----------------------------------------------------------------------------
module tmrls_mdu (
  input  logic               clk,
  input  logic               rst,
  input  tmrls_pkg::mdu_req_t req,
  input  logic [65:0]        opnd_in,
  input  logic [65:0]        acc_init,
  input  logic [47:0]        shf_init,
  output tmrls_pkg::mdu_sts_t sts,
  output logic [83:0]        prod,
  output logic [47:0]        quo
);

  logic                busy;
  logic                done;
  logic                ovf;
  tmrls_pkg::mdu_op_t  op_q;
  logic [5:0]          cnt;
  logic [65:0]         opnd;
  logic [83:0]         acc;
  logic [47:0]         shf;
  logic                is_div;
  logic [83:0]         x;
  logic [83:0]         y;
  logic [84:0]         s;
  logic                qbit;
  logic [83:0]         res;

  // One add or subtract step of the running operation.
  always_comb begin
    is_div = (op_q == tmrls_pkg::MDU_DIV);
    x = {acc[82:0], is_div & shf[47]};
    if (is_div || shf[47]) begin
      y = {18'd0, opnd};
    end else begin
      y = '0;
    end
    s = {1'b0, x} + {1'b0, is_div ? ~y : y} + {84'd0, is_div};
    qbit = is_div & s[84];
    if (is_div && !s[84]) begin
      res = x;
    end else begin
      res = s[83:0];
    end
  end

  // Control: a start loads the operands, the count runs down to completion.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == 6'd1) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (req.start) begin
      op_q <= req.op;
      cnt  <= req.nbits;
      opnd <= opnd_in;
      shf  <= shf_init;
      if (req.op == tmrls_pkg::MDU_DIV) begin
        acc <= {18'd0, acc_init};
        ovf <= (acc_init >= opnd_in);
      end else begin
        acc <= '0;
        ovf <= 1'b0;
      end
    end else if (busy) begin
      acc <= res;
      shf <= {shf[46:0], qbit};
      cnt <= cnt - 6'd1;
    end
  end

  assign sts.busy = busy;
  assign sts.done = done;
  assign sts.ovf  = ovf;
  assign prod     = acc;
  assign quo      = shf;

endmodule
